// ----- rtl/core/qte_pkg.sv -----
package qte_pkg;

	// arctangent table, atan(2^-i) in 1/1024 millidegree, rounded to nearest
	localparam int TAB_LEN = 24;
	localparam logic [27:0] ATAN_TAB [TAB_LEN] = '{
		28'd46080000, 28'd27202612, 28'd14373113, 28'd7296017,
		28'd3662166,  28'd1832868,  28'd916658,   28'd458357,
		28'd229182,   28'd114591,   28'd57296,    28'd28648,
		28'd14324,    28'd7162,     28'd3581,     28'd1790,
		28'd895,      28'd448,      28'd224,      28'd112,
		28'd56,       28'd28,       28'd14,       28'd7
	};

	localparam int ANG_SCALE_BITS = 10;
	localparam int NORM_BITS      = 29;     // larger lands in [2^28, 2^29)
	localparam int XY_W           = 32;
	localparam int Z_W            = 31;
	localparam int HALF_TURN      = 180000 * 1024;

	localparam int SQRT_STEPS = 31;
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int REM_W      = 32;
	localparam int S30_W      = 32;

	localparam int QDEPTH = 4;

	localparam int ROLL_LIM  = 180000;
	localparam int PITCH_LIM = 90000;
	localparam int ROLL_W    = 19;
	localparam int PITCH_W   = 18;

	// width of the quadratic forms: 2^(2F) plus a 2^32 swing, signed
	function automatic int qw_of(input int frac_bits);
		return ((2 * frac_bits > 32) ? 2 * frac_bits : 32) + 3;
	endfunction

endpackage

// ----- rtl/core/qte_ifs.sv -----
interface qte_quat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface

interface qte_euler_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] roll_mdeg;
	logic signed [17:0] pitch_mdeg;
	logic signed [18:0] yaw_mdeg;

	modport source (output valid, output roll_mdeg, output pitch_mdeg,
		output yaw_mdeg, input ready);
	modport sink (input valid, input roll_mdeg, input pitch_mdeg,
		input yaw_mdeg, output ready);
endinterface

// ----- rtl/core/qte_front.sv -----
module qte_front import qte_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	qte_quat_if.sink                           quat,
	output logic                               push,
	output logic [5*qw_of(FRAC_BITS)-1:0]      push_data,
	input  logic                               full
);

	localparam int QW = qw_of(FRAC_BITS);
	localparam logic signed [QW-1:0] ONE2 = {{(QW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

	logic v_s1, v_s2, adv1, adv2;
	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wz_s1;
	logic signed [31:0] p_xy_s1, p_zz_s1, p_wy_s1, p_zx_s1;
	logic signed [QW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;

	// each stage holds while the one after it is blocked
	assign push       = v_s2 && !full;
	assign adv2       = !v_s2 || !full;
	assign adv1       = !v_s1 || adv2;
	assign quat.ready = adv1;
	assign push_data  = {sp_s2, cy_s2, sy_s2, cr_s2, sr_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= quat.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_wx_s1 <= quat.quat_w * quat.quat_x;
			p_yz_s1 <= quat.quat_y * quat.quat_z;
			p_xx_s1 <= quat.quat_x * quat.quat_x;
			p_yy_s1 <= quat.quat_y * quat.quat_y;
			p_wz_s1 <= quat.quat_w * quat.quat_z;
			p_xy_s1 <= quat.quat_x * quat.quat_y;
			p_zz_s1 <= quat.quat_z * quat.quat_z;
			p_wy_s1 <= quat.quat_w * quat.quat_y;
			p_zx_s1 <= quat.quat_z * quat.quat_x;
		end
		if (adv2) begin
			sr_s2 <= (QW'(p_wx_s1) + QW'(p_yz_s1)) <<< 1;
			cr_s2 <= ONE2 - ((QW'(p_xx_s1) + QW'(p_yy_s1)) <<< 1);
			sy_s2 <= (QW'(p_wz_s1) + QW'(p_xy_s1)) <<< 1;
			cy_s2 <= ONE2 - ((QW'(p_yy_s1) + QW'(p_zz_s1)) <<< 1);
			sp_s2 <= (QW'(p_wy_s1) - QW'(p_zx_s1)) <<< 1;
		end
	end

endmodule

// ----- rtl/core/qte_queue.sv -----
module qte_queue import qte_pkg::*; #(
	parameter int DW = 175
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] head,
	output logic          empty
);

	localparam int PW = $clog2(QDEPTH);

	logic [DW-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count lost a pop");

endmodule

// ----- rtl/core/qte_atan2.sv -----
module qte_atan2 import qte_pkg::*; #(
	parameter int QW    = 35,
	parameter int STEPS = 16,
	parameter int LIM   = 180000,
	parameter int AW    = 19
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [QW-1:0] ny,
	input  logic signed [QW-1:0] nx,
	output logic signed [AW-1:0] angle
);

	localparam int LZW = $clog2(QW);

	logic [QW-1:0]  ay_s1, ax_s1, m_s1, ay_s2, ax_s2;
	logic           yneg_s1, xneg_s1, zero_s1, yneg_s2, xneg_s2, zero_s2;
	logic [LZW-1:0] lz_s2;
	logic [LZW-1:0] lz;
	logic [QW-1:0]  ay_c, ax_c, ax_al, ay_al;
	logic signed [XY_W-1:0] x0, y0;
	logic signed [Z_W-1:0]  z0;

	logic signed [XY_W-1:0] cx_s [STEPS+1];
	logic signed [XY_W-1:0] cy_s [STEPS+1];
	logic signed [Z_W-1:0]  cz_s [STEPS+1];
	logic                   zf_s [STEPS+1];

	logic signed [31:0] rnd, rsh;

	assign ay_c = ny[QW-1] ? QW'(-ny) : QW'(ny);
	assign ax_c = nx[QW-1] ? QW'(-nx) : QW'(nx);

	// leading-zero count of the larger magnitude
	always_comb begin
		lz = '0;
		for (int i = 0; i < QW; i++) begin
			if (m_s1[i]) lz = LZW'(QW - 1 - i);
		end
	end

	// left-align and keep the top bits: same as the truncating rescale
	always_comb begin
		ax_al = ax_s2 << lz_s2;
		ay_al = ay_s2 << lz_s2;
		x0 = XY_W'(ax_al[QW-1 -: NORM_BITS]);
		y0 = XY_W'(ay_al[QW-1 -: NORM_BITS]);
		if (yneg_s2) y0 = -y0;
		z0 = '0;
		if (xneg_s2 && x0 != '0) begin
			z0 = (yneg_s2 && y0 != '0) ? -Z_W'(HALF_TURN) : Z_W'(HALF_TURN);
			y0 = -y0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1   <= ay_c;
			ax_s1   <= ax_c;
			m_s1    <= (ay_c > ax_c) ? ay_c : ax_c;
			yneg_s1 <= ny[QW-1];
			xneg_s1 <= nx[QW-1];
			zero_s1 <= (ay_c == '0) && (ax_c == '0);
			ay_s2   <= ay_s1;
			ax_s2   <= ax_s1;
			yneg_s2 <= yneg_s1;
			xneg_s2 <= xneg_s1;
			zero_s2 <= zero_s1;
			lz_s2   <= lz;
			cx_s[0] <= x0;
			cy_s[0] <= y0;
			cz_s[0] <= z0;
			zf_s[0] <= zero_s2;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [Z_W-1:0] tab;
		assign tab = Z_W'(ATAN_TAB[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + tab;
				end else if (cy_s[i] < 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - tab;
				end else begin
					cx_s[i+1] <= cx_s[i];
					cy_s[i+1] <= cy_s[i];
					cz_s[i+1] <= cz_s[i];
				end
			end
		end
	end

	assign rnd = 32'(cz_s[STEPS]) + 32'sd512;
	assign rsh = rnd >>> ANG_SCALE_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf_s[STEPS])     angle <= '0;
			else if (rsh > LIM)  angle <= AW'(LIM);
			else if (rsh < -LIM) angle <= AW'(-LIM);
			else                 angle <= AW'(rsh);
		end
	end

endmodule

// ----- rtl/core/qte_back.sv -----
module qte_back import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [5*qw_of(FRAC_BITS)-1:0] head,
	input  logic                          empty,
	output logic                          pop,
	qte_euler_if.source                   euler
);

	localparam int QW   = qw_of(FRAC_BITS);
	localparam int D    = 2 * FRAC_BITS - 30;
	localparam int DR   = (D > 0) ? D : 0;
	localparam int DL   = (D < 0) ? -D : 0;
	localparam int PAYW = 4 * QW + S30_W;
	localparam int NV   = 2 + SQRT_STEPS + 4 + CORDIC_STEPS;

	logic          en;
	logic [NV-1:0] vld_q;

	logic signed [QW-1:0] sp;
	logic [QW-1:0]        sp_mag;
	logic [QW+9:0]        a_wide;
	logic [30:0]          a_c;

	logic [30:0]          a_s0;
	logic                 neg_s0;
	logic [4*QW-1:0]      fwd_s0;
	logic [RAD_W-1:0]     sq;
	logic [RAD_W-1:0]     rad_s1;
	logic [PAYW-1:0]      pay_s1;
	logic signed [S30_W-1:0] s30;

	logic [RAD_W-1:0]  rad_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];
	logic [REM_W-1:0]  rem_s  [SQRT_STEPS];
	logic [PAYW-1:0]   pay_s  [SQRT_STEPS];

	logic signed [QW-1:0] sr_f, cr_f, sy_f, cy_f, sp_y, cp_x;

	// whole back pipeline moves together; stall only on a blocked result
	assign en  = !euler.valid || euler.ready;
	assign pop = en && !empty;
	assign euler.valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NV-2:0], pop};
	end

	// pitch sine: rescale to 30 fraction bits, clamp to one
	assign sp     = head[5*QW-1 -: QW];
	assign sp_mag = sp[QW-1] ? QW'(-sp) : QW'(sp);
	assign a_wide = ({10'd0, sp_mag} << DL) >> DR;
	assign a_c    = (a_wide > ((QW+10)'(1) << 30)) ? 31'(1) << 30 : a_wide[30:0];
	assign sq     = {31'd0, a_s0} * {31'd0, a_s0};
	assign s30    = neg_s0 ? -S30_W'(a_s0) : S30_W'(a_s0);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s0   <= a_c;
			neg_s0 <= sp[QW-1];
			fwd_s0 <= head[4*QW-1:0];
			rad_s1 <= (RAD_W'(1) << 60) - sq;
			pay_s1 <= {s30, fwd_s0};
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [RAD_W-1:0]  rad_i;
		logic [ROOT_W-1:0] root_i;
		logic [REM_W-1:0]  rem_i;
		logic [PAYW-1:0]   pay_i;
		logic [REM_W+1:0]  r4, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_i  = rad_s1;
			assign root_i = '0;
			assign rem_i  = '0;
			assign pay_i  = pay_s1;
		end else begin : g_next
			assign rad_i  = rad_s[k-1];
			assign root_i = root_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign pay_i  = pay_s[k-1];
		end

		assign r4    = {rem_i, rad_i[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = r4 >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_i << 2;
				root_s[k] <= {root_i[ROOT_W-2:0], ge};
				rem_s[k]  <= ge ? REM_W'(r4 - trial) : REM_W'(r4);
				pay_s[k]  <= pay_i;
			end
		end
	end

	assign sr_f = pay_s[SQRT_STEPS-1][QW-1:0];
	assign cr_f = pay_s[SQRT_STEPS-1][2*QW-1:QW];
	assign sy_f = pay_s[SQRT_STEPS-1][3*QW-1:2*QW];
	assign cy_f = pay_s[SQRT_STEPS-1][4*QW-1:3*QW];
	assign sp_y = QW'($signed(pay_s[SQRT_STEPS-1][PAYW-1 -: S30_W]));
	assign cp_x = QW'(root_s[SQRT_STEPS-1]);

	qte_atan2 #(.QW(QW), .STEPS(CORDIC_STEPS), .LIM(ROLL_LIM), .AW(ROLL_W)) u_roll (
		.clk(clk), .en(en), .ny(sr_f), .nx(cr_f), .angle(euler.roll_mdeg)
	);

	qte_atan2 #(.QW(QW), .STEPS(CORDIC_STEPS), .LIM(PITCH_LIM), .AW(PITCH_W)) u_pitch (
		.clk(clk), .en(en), .ny(sp_y), .nx(cp_x), .angle(euler.pitch_mdeg)
	);

	qte_atan2 #(.QW(QW), .STEPS(CORDIC_STEPS), .LIM(ROLL_LIM), .AW(ROLL_W)) u_yaw (
		.clk(clk), .en(en), .ny(sy_f), .nx(cy_f), .angle(euler.yaw_mdeg)
	);

endmodule

// ----- rtl/core/quaternion_to_euler_angles_core.sv -----
// Quaternion (Q2.14) to ZYX roll/pitch/yaw in millidegrees.
// Path: front product and quadratic-form registers, the queue, then the back
// pipeline's pitch-sine, square-root and CORDIC registers. Throughput one request
// per cycle unless results stall, set by the fully unrolled square-root and CORDIC
// pipelines. Reset (arst_n low) clears only the valid bits, queue pointers and
// count; payload registers are not reset.
module quaternion_to_euler_angles_core import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);

	localparam int QW = qw_of(FRAC_BITS);
	localparam int DW = 5 * QW;

	// front: products and quadratic forms for the three angles
	logic          push, full, pop, empty;
	logic [DW-1:0] push_data, head;

	qte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .quat(quat),
		.push(push), .push_data(push_data), .full(full)
	);

	// short queue: lets the front keep taking requests while results stall, until it fills
	qte_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .head(head), .empty(empty)
	);

	// back: pitch sine clamp, cosine square root, three CORDIC lanes;
	// the lanes' final registers are the output register
	qte_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .empty(empty), .pop(pop), .euler(euler)
	);

endmodule
